FILE: rtl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Node type, sentinel and combine arithmetic for the max subarray sum tree.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int unsigned NODE_W = 48;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned VAL_W  = 31;
  localparam int unsigned OUT_W  = 40;

  localparam logic signed [NODE_W-1:0] SENTINEL = -48'sd10000000000001;

  typedef struct packed {
    logic signed [NODE_W-1:0] total;
    logic signed [NODE_W-1:0] prefix;
    logic signed [NODE_W-1:0] suffix;
    logic signed [NODE_W-1:0] best;
  } node_t;

  // one node moving up the chain
  typedef struct packed {
    logic  vld;
    node_t node;
  } node_tok_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic launch;  // latch path index, read sibling
    logic clr;     // clearing pass write
  } cell_ctl_t;

  localparam node_t SENT_NODE = '{total: SENTINEL, prefix: SENTINEL,
                                  suffix: SENTINEL, best: SENTINEL};

  function automatic logic signed [NODE_W-1:0] sat_add(
    input logic signed [NODE_W-1:0] a,
    input logic signed [NODE_W-1:0] b
  );
    logic signed [NODE_W:0] s;
    s = (NODE_W+1)'(a) + (NODE_W+1)'(b);
    if (s < (NODE_W+1)'(SENTINEL)) begin
      return SENTINEL;
    end
    return s[NODE_W-1:0];
  endfunction

  function automatic logic signed [NODE_W-1:0] max2(
    input logic signed [NODE_W-1:0] a,
    input logic signed [NODE_W-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

  function automatic node_t combine(input node_t l, input node_t r);
    node_t n;
    n.total  = sat_add(l.total, r.total);
    n.prefix = max2(l.prefix, sat_add(l.total, r.prefix));
    n.suffix = max2(r.suffix, sat_add(r.total, l.suffix));
    n.best   = max2(max2(l.best, r.best), sat_add(l.suffix, r.prefix));
    return n;
  endfunction

endpackage

FILE: rtl/mss_cell.sv
// ----------------------------------------------------------------------------
// mss_cell
// One tree level: stores the level's nodes, writes the updated path node and
// hands its parent (path node combined with sibling) to the next level up.
// ----------------------------------------------------------------------------
module mss_cell #(
  parameter int unsigned LEVEL = 1,
  parameter int unsigned LVL   = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mss_pkg::cell_ctl_t   ctl,
  input  logic [LVL-1:0]       pos_i,
  input  logic [LVL-1:0]       clr_addr_i,
  input  mss_pkg::node_tok_t   tok_i,
  output mss_pkg::node_tok_t   tok_o
);

  localparam int unsigned DEPTH = 1 << LEVEL;

  mss_pkg::node_t mem_r [DEPTH];
  mss_pkg::node_t sib_r;
  mss_pkg::node_t par_r;
  mss_pkg::node_t par_nxt;
  mss_pkg::node_t left;
  mss_pkg::node_t right;
  logic [LEVEL-1:0] idx_r;
  logic [LEVEL-1:0] idx_nxt;
  logic             vld_r;

  // path node index at this level: top LEVEL bits of the leaf index
  assign idx_nxt = pos_i[LVL-1 -: LEVEL];

  always_ff @(posedge clk) begin
    if (ctl.launch) begin
      idx_r <= idx_nxt;
      sib_r <= mem_r[idx_nxt ^ LEVEL'(1)];
    end
    if (ctl.clr) begin
      mem_r[clr_addr_i[LEVEL-1:0]] <= mss_pkg::SENT_NODE;
    end else if (tok_i.vld) begin
      mem_r[idx_r] <= tok_i.node;
    end
  end

  assign left    = idx_r[0] ? sib_r : tok_i.node;
  assign right   = idx_r[0] ? tok_i.node : sib_r;
  assign par_nxt = mss_pkg::combine(left, right);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= tok_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    par_r <= par_nxt;
  end

  assign tok_o.vld  = vld_r;
  assign tok_o.node = par_r;

endmodule

FILE: rtl/max_subarray_sum_segment_tree.sv
// ----------------------------------------------------------------------------
// max_subarray_sum_segment_tree
// Point-update segment tree reporting the maximum subarray sum (floor zero).
//
//   channel  | ports                              | handshake
//   ---------+------------------------------------+-----------------------
//   input    | in_position, in_value              | start && !busy
//   result   | out_best_sum                       | out_valid, 1-cycle beat
//
// Flow: an in-range beat is registered as a leaf node, climbs the cell chain
// with a register in the cell of every tree level, and its result beat is
// registered from the root. An out-of-range position is answered from the
// current root in the cycle after the beat. A new beat may be taken while the
// previous result shows. Reset's clearing pass, busy high, covers every leaf
// address (LEAVES rounded up to a power of two). The receiver cannot stall.
// ----------------------------------------------------------------------------
module max_subarray_sum_segment_tree #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [mss_pkg::POS_W-1:0]            in_position,
  input  logic signed [mss_pkg::VAL_W-1:0]     in_value,
  output logic                                 out_valid,
  output logic [mss_pkg::OUT_W-1:0]            out_best_sum
);

  // levels below the root; leaf level has 2**LVL nodes
  localparam int unsigned LVL = $clog2(LEAVES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0]     state_r, state_nxt;
  logic [LVL-1:0] clr_cnt_r, clr_cnt_nxt;
  logic signed [mss_pkg::NODE_W-1:0] root_best_r, root_best_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [mss_pkg::OUT_W-1:0] out_best_r, out_best_nxt;
  logic           leaf_vld_r;
  mss_pkg::node_t leaf_node_r;

  logic           accept;
  logic           in_range;
  logic signed [mss_pkg::NODE_W-1:0] val_ext;
  mss_pkg::cell_ctl_t ctl;
  mss_pkg::node_tok_t tok [0:LVL];

  function automatic logic [mss_pkg::OUT_W-1:0] clamp(
    input logic signed [mss_pkg::NODE_W-1:0] b
  );
    return (b < 0) ? '0 : b[mss_pkg::OUT_W-1:0];
  endfunction

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = 32'(in_position) < LEAVES;
  assign val_ext  = mss_pkg::NODE_W'(in_value);

  assign ctl.launch = accept && in_range;
  assign ctl.clr    = (state_r == ST_CLEAR);

  // leaf beat enters the chain at the leaf level
  assign tok[LVL].vld  = leaf_vld_r;
  assign tok[LVL].node = leaf_node_r;

  // cell at level d takes tok[d] and emits its parent on tok[d-1]
  for (genvar d = 1; d <= LVL; d++) begin : g_level
    mss_cell #(
      .LEVEL (d),
      .LVL   (LVL)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .pos_i      (LVL'(in_position)),
      .clr_addr_i (clr_cnt_r),
      .tok_i      (tok[d]),
      .tok_o      (tok[d-1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    root_best_nxt = root_best_r;
    out_valid_nxt = 1'b0;
    out_best_nxt  = out_best_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + LVL'(1);
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_range) begin
            state_nxt = ST_RUN;
          end else begin
            // nothing changes: report the current root
            out_valid_nxt = 1'b1;
            out_best_nxt  = clamp(root_best_r);
          end
        end
      end
      ST_RUN: begin
        if (tok[0].vld) begin
          state_nxt     = ST_IDLE;
          root_best_nxt = tok[0].node.best;
          out_valid_nxt = 1'b1;
          out_best_nxt  = clamp(tok[0].node.best);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      root_best_r <= mss_pkg::SENTINEL;
      out_valid_r <= 1'b0;
      leaf_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      root_best_r <= root_best_nxt;
      out_valid_r <= out_valid_nxt;
      leaf_vld_r  <= accept && in_range;
    end
  end

  always_ff @(posedge clk) begin
    out_best_r <= out_best_nxt;
    if (accept) begin
      leaf_node_r <= '{total: val_ext, prefix: val_ext, suffix: val_ext, best: val_ext};
    end
  end

  assign out_valid    = out_valid_r;
  assign out_best_sum = out_best_r;

endmodule

FILE: rtl/mss_checker.sv
// ----------------------------------------------------------------------------
// mss_checker
// Port-level checks for max_subarray_sum_segment_tree.
// ----------------------------------------------------------------------------
module mss_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // after reset the clearing pass holds the block busy
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // a result beat is only shown once the block is free again
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // an accepted beat either answers next cycle or keeps the block busy
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted beat dropped");

  // outside reset, busy only rises because a beat was taken
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(busy) && $past(rst_n)) |-> $past(start))
    else $error("busy rose without a beat");

endmodule

bind max_subarray_sum_segment_tree mss_checker u_mss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
